>>> design/hnee_pkg.sv
// shared types and constants for the html numeric entity escaper
// used by every module of the block; depends on nothing
package hnee_pkg;

    localparam int CP_W       = 21;
    localparam int CHAR_W     = 7;
    localparam int NUM_ESC    = 4;
    localparam int MAX_DIGITS = 7;
    localparam int ND_W       = 3;
    localparam int DIGIT_W    = 4;
    localparam int POS_W      = 4;
    localparam int CFG_IDX_W  = 3;

    localparam int FIFO_DEPTH_DEF = 2;

    // x / 10 == (x * RECIP_10) >> RECIP_SHIFT, exact for any 21-bit x
    localparam logic [CP_W-1:0] RECIP_10    = 21'd1677722;
    localparam int              RECIP_SHIFT = 24;
    localparam int              PROD_W      = 2 * CP_W;
    localparam int              QUOT_W      = PROD_W - RECIP_SHIFT;

    localparam logic [CHAR_W-1:0] CH_AMP  = 7'h26;
    localparam logic [CHAR_W-1:0] CH_HASH = 7'h23;
    localparam logic [CHAR_W-1:0] CH_SEMI = 7'h3B;
    localparam logic [CHAR_W-1:0] CH_ZERO = 7'h30;

    localparam logic [CFG_IDX_W-1:0] REG_ESC_A  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ESC_B  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ESC_C  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ESC_D  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ENABLE = 3'd4;

    localparam logic [CHAR_W-1:0]  RST_ESC_A  = 7'd60;
    localparam logic [CHAR_W-1:0]  RST_ESC_B  = 7'd62;
    localparam logic [CHAR_W-1:0]  RST_ESC_C  = 7'd39;
    localparam logic [CHAR_W-1:0]  RST_ESC_D  = 7'd38;
    localparam logic [NUM_ESC-1:0] RST_ENABLE = 4'hF;

    typedef struct packed {
        logic [NUM_ESC-1:0][CHAR_W-1:0] chars;
        logic [NUM_ESC-1:0]             enable;
    } esc_cfg_t;

    // one queue entry: a plain character or a decimal run, digits lsd first
    typedef struct packed {
        logic                                  esc;
        logic [CHAR_W-1:0]                     ch;
        logic [ND_W-1:0]                       nd;
        logic [MAX_DIGITS-1:0][DIGIT_W-1:0]    digits;
    } entry_t;

endpackage

>>> design/hnee_front.sv
// front end: accepts code points, classifies them and splits escaped ones
// into decimal digits, one digit per cycle, the last one waiting while the queue is full; depends on hnee_pkg
module hnee_front
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [hnee_pkg::CP_W-1:0]    code_point,
    input  hnee_pkg::esc_cfg_t           cfg,
    output logic                         push_valid,
    output hnee_pkg::entry_t             push_data,
    input  logic                         fifo_full
);

    logic                                                    busy_reg, busy_next;
    logic [hnee_pkg::CP_W-1:0]                               val_reg, val_next;
    logic [hnee_pkg::ND_W-1:0]                               nd_reg, nd_next;
    logic [hnee_pkg::MAX_DIGITS-1:0][hnee_pkg::DIGIT_W-1:0]  digits_reg, digits_next;
    logic [hnee_pkg::MAX_DIGITS-1:0][hnee_pkg::DIGIT_W-1:0]  digits_done;

    logic                               accept;
    logic                               matched;
    logic                               plain;
    logic [hnee_pkg::PROD_W-1:0]        prod;
    logic [hnee_pkg::CP_W-1:0]          quot;
    logic [hnee_pkg::CP_W-1:0]          rem;
    logic                               final_digit;
    logic                               step;

    assign in_ready = !busy_reg && !fifo_full;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        matched = 1'b0;
        for (int k = 0; k < hnee_pkg::NUM_ESC; k++)
        begin
            if (cfg.enable[k] && (cfg.chars[k] == code_point[hnee_pkg::CHAR_W-1:0]))
            begin
                matched = 1'b1;
            end
        end
    end

    assign plain = (code_point[hnee_pkg::CP_W-1:hnee_pkg::CHAR_W] == '0) && !matched;

    // divide by ten through a reciprocal multiply
    assign prod = {{hnee_pkg::CP_W{1'b0}}, val_reg} *
                  {{hnee_pkg::CP_W{1'b0}}, hnee_pkg::RECIP_10};
    assign quot = hnee_pkg::CP_W'(prod[hnee_pkg::PROD_W-1:hnee_pkg::RECIP_SHIFT]);
    assign rem  = val_reg - ((quot << 3) + (quot << 1));

    assign final_digit = (quot == '0) ||
                         (nd_reg == hnee_pkg::ND_W'(hnee_pkg::MAX_DIGITS - 1));
    assign step = busy_reg && (!final_digit || !fifo_full);

    always_comb
    begin
        digits_done         = digits_reg;
        digits_done[nd_reg] = rem[hnee_pkg::DIGIT_W-1:0];
    end

    always_comb
    begin
        busy_next   = busy_reg;
        val_next    = val_reg;
        nd_next     = nd_reg;
        digits_next = digits_reg;
        if (accept && (code_point != '0) && !plain)
        begin
            busy_next = 1'b1;
            val_next  = code_point;
            nd_next   = '0;
        end
        else if (step)
        begin
            val_next    = quot;
            nd_next     = nd_reg + 1'b1;
            digits_next = digits_done;
            if (final_digit)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_comb
    begin
        push_valid = 1'b0;
        push_data  = '0;
        if (busy_reg)
        begin
            push_valid       = final_digit && !fifo_full;
            push_data.esc    = 1'b1;
            push_data.nd     = nd_reg + 1'b1;
            push_data.digits = digits_done;
        end
        else if (accept && (code_point != '0) && plain)
        begin
            push_valid   = 1'b1;
            push_data.ch = code_point[hnee_pkg::CHAR_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg    <= val_next;
        nd_reg     <= nd_next;
        digits_reg <= digits_next;
    end

endmodule

>>> design/hnee_fifo.sv
// short queue of classified entries between front and back end
// depends on hnee_pkg
module hnee_fifo
#(
    parameter int DEPTH = hnee_pkg::FIFO_DEPTH_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  hnee_pkg::entry_t  push_data,
    output logic              full,
    input  logic              pop,
    output logic              empty,
    output hnee_pkg::entry_t  head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    hnee_pkg::entry_t   store [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               do_push, do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = store[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            store[wr_ptr_reg] <= push_data;
        end
    end

endmodule

>>> design/hnee_back.sv
// back end: walks the head entry and emits one byte per beat into an
// output register; depends on hnee_pkg
module hnee_back
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          head_valid,
    input  hnee_pkg::entry_t              head,
    output logic                          pop,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [hnee_pkg::CHAR_W-1:0]   out_byte,
    output logic                          run_last
);

    localparam logic [hnee_pkg::POS_W-1:0] POS_AMP  = 4'd0;
    localparam logic [hnee_pkg::POS_W-1:0] POS_HASH = 4'd1;

    logic [hnee_pkg::POS_W-1:0]   pos_reg, pos_next;
    logic                         out_valid_reg, out_valid_next;
    logic [hnee_pkg::CHAR_W-1:0]  out_byte_reg, out_byte_next;
    logic                         run_last_reg, run_last_next;

    logic                         load;
    logic [hnee_pkg::CHAR_W-1:0]  beat_byte;
    logic                         beat_last;
    logic [hnee_pkg::POS_W-1:0]   digit_sel;
    logic [hnee_pkg::DIGIT_W-1:0] digit;

    assign load = head_valid && (!out_valid_reg || out_ready);

    // digits are held lsd first, so the run reads them from the top down
    assign digit_sel = {1'b0, head.nd} + 1'b1 - pos_reg;
    assign digit     = head.digits[digit_sel[hnee_pkg::ND_W-1:0]];

    always_comb
    begin
        beat_byte = head.ch;
        beat_last = 1'b1;
        if (head.esc)
        begin
            beat_last = 1'b0;
            case (pos_reg)
                POS_AMP:  beat_byte = hnee_pkg::CH_AMP;
                POS_HASH: beat_byte = hnee_pkg::CH_HASH;
                default:
                begin
                    if (pos_reg == ({1'b0, head.nd} + 4'd2))
                    begin
                        beat_byte = hnee_pkg::CH_SEMI;
                        beat_last = 1'b1;
                    end
                    else
                    begin
                        beat_byte = hnee_pkg::CH_ZERO | {3'b000, digit};
                    end
                end
            endcase
        end
    end

    assign pop = load && beat_last;

    always_comb
    begin
        pos_next       = pos_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_byte_next  = out_byte_reg;
        run_last_next  = run_last_reg;
        if (load)
        begin
            pos_next       = beat_last ? '0 : pos_reg + 1'b1;
            out_valid_next = 1'b1;
            out_byte_next  = beat_byte;
            run_last_next  = beat_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg       <= pos_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_byte_reg <= out_byte_next;
        run_last_reg <= run_last_next;
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign run_last  = run_last_reg;

endmodule

>>> design/html_numeric_entity_escaper_core.sv
// html numeric entity escaper, top level; holds the escape registers
// path: a plain character goes through the queue and then the output register;
// an escaped one first splits into d decimal digits (up to 7); its run opens with '&'
// throughput unless the output stalls: one plain character per cycle; an escaped run
// leaves at one byte per cycle (d + 3 bytes), set by the single output byte lane
// reset: asynchronous, active low; empties the queue and restores default escapes
module html_numeric_entity_escaper_core
#(
    parameter int FIFO_DEPTH = hnee_pkg::FIFO_DEPTH_DEF
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [hnee_pkg::CP_W-1:0]       code_point,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [hnee_pkg::CHAR_W-1:0]     out_byte,
    output logic                            run_last,
    input  logic                            cfg_wr_en,
    input  logic [hnee_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [hnee_pkg::CHAR_W-1:0]     cfg_data
);

    hnee_pkg::esc_cfg_t  cfg_reg, cfg_next;
    hnee_pkg::entry_t    push_data;
    hnee_pkg::entry_t    head;
    logic                push_valid;
    logic                fifo_full;
    logic                fifo_empty;
    logic                pop;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            case (cfg_index)
                hnee_pkg::REG_ESC_A:  cfg_next.chars[0] = cfg_data;
                hnee_pkg::REG_ESC_B:  cfg_next.chars[1] = cfg_data;
                hnee_pkg::REG_ESC_C:  cfg_next.chars[2] = cfg_data;
                hnee_pkg::REG_ESC_D:  cfg_next.chars[3] = cfg_data;
                hnee_pkg::REG_ENABLE: cfg_next.enable = cfg_data[hnee_pkg::NUM_ESC-1:0];
                default:              cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.chars[0] <= hnee_pkg::RST_ESC_A;
            cfg_reg.chars[1] <= hnee_pkg::RST_ESC_B;
            cfg_reg.chars[2] <= hnee_pkg::RST_ESC_C;
            cfg_reg.chars[3] <= hnee_pkg::RST_ESC_D;
            cfg_reg.enable   <= hnee_pkg::RST_ENABLE;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    hnee_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .code_point (code_point),
        .cfg        (cfg_reg),
        .push_valid (push_valid),
        .push_data  (push_data),
        .fifo_full  (fifo_full)
    );

    hnee_fifo
    #(
        .DEPTH (FIFO_DEPTH)
    )
    u_fifo
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push_valid),
        .push_data (push_data),
        .full      (fifo_full),
        .pop       (pop),
        .empty     (fifo_empty),
        .head      (head)
    );

    hnee_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (!fifo_empty),
        .head       (head),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_byte   (out_byte),
        .run_last   (run_last)
    );

endmodule

>>> design/hnee_checker.sv
// port-level checks for the escaper output stream, bound to the top level
// depends on hnee_pkg and html_numeric_entity_escaper_core
module hnee_checker
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         out_valid,
    input  logic                         out_ready,
    input  logic [hnee_pkg::CHAR_W-1:0]  out_byte,
    input  logic                         run_last
);

    // a stalled beat holds its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(run_last))
        else $error("output beat changed while stalled");

    // inside a run only '&', '#' and decimal digits come before the last beat
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !run_last |->
            (out_byte == hnee_pkg::CH_AMP) || (out_byte == hnee_pkg::CH_HASH) ||
            ((out_byte >= hnee_pkg::CH_ZERO) && (out_byte <= 7'h39)))
        else $error("unexpected byte inside an escape run");

    // a run never pauses once started
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !run_last |=> out_valid)
        else $error("gap inside an escape run");

    // a digit beat that is taken is followed by another digit or the closing ';'
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !run_last && (out_byte >= hnee_pkg::CH_ZERO) |=>
            (out_byte == hnee_pkg::CH_SEMI && run_last) ||
            ((out_byte >= hnee_pkg::CH_ZERO) && (out_byte <= 7'h39) && !run_last))
        else $error("digit beat not followed by digit or terminator");

endmodule

bind html_numeric_entity_escaper_core hnee_checker u_hnee_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_byte  (out_byte),
    .run_last  (run_last)
);

>>> dv/testbench.sv
`timescale 1ns / 1ps
// testbench for html_numeric_entity_escaper_core: a directed table, then random phases
// each checked against an in-bench text predictor; needs design/hnee_pkg.sv and the core
module testbench;

    localparam int CLK_PERIOD      = 20;
    localparam int SETTLE_CYCLES   = 16;
    localparam int HOLD_OFF_CYCLES = 200;
    localparam int LIMIT_CYCLES    = 300000;
    localparam int PHASES          = 5;
    localparam int PHASE_ITEMS     = 50;
    localparam int MAX_REPORTS     = 10;

    typedef enum {ROW_CHAR, ROW_REG} row_kind_t;

    typedef struct {
        row_kind_t                       kind;
        logic [hnee_pkg::CP_W-1:0]       cp;
        logic [hnee_pkg::CFG_IDX_W-1:0]  idx;
        logic [hnee_pkg::CHAR_W-1:0]     val;
        string                           txt;   // "*" means work it out with the predictor
    } stim_row_t;

    typedef struct packed {
        logic [hnee_pkg::CHAR_W-1:0] ch;
        logic                        last;
    } due_byte_t;

    logic                            clk;
    logic                            rst_n;
    logic                            in_valid;
    logic                            in_ready;
    logic [hnee_pkg::CP_W-1:0]       code_point;
    logic                            out_valid;
    logic                            out_ready;
    logic [hnee_pkg::CHAR_W-1:0]     out_byte;
    logic                            run_last;
    logic                            cfg_wr_en;
    logic [hnee_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [hnee_pkg::CHAR_W-1:0]     cfg_data;

    // shadow copy of the escape registers
    logic [hnee_pkg::CHAR_W-1:0]     esc_chars [hnee_pkg::NUM_ESC];
    logic [hnee_pkg::NUM_ESC-1:0]    esc_en;

    due_byte_t             bytes_due [$];
    stim_row_t             rows [$];
    int                    mismatches;
    bit                    idle_on;
    bit                    hold_off_req;

    html_numeric_entity_escaper_core uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .code_point (code_point),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_byte   (out_byte),
        .run_last   (run_last),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    initial clk = 1'b0;
    always #(CLK_PERIOD / 2) clk = ~clk;

    task automatic push_text(input string txt);
        due_byte_t b;
        for (int i = 0; i < txt.len(); i++)
        begin
            b.ch   = hnee_pkg::CHAR_W'(txt[i]);
            b.last = (i == txt.len() - 1);
            bytes_due.push_back(b);
        end
    endtask

    // plain byte, numeric reference, or nothing at all for the terminator
    task automatic escape_code_point(input logic [hnee_pkg::CP_W-1:0] cp);
        bit        hit;
        due_byte_t b;
        hit = 1'b0;
        for (int k = 0; k < hnee_pkg::NUM_ESC; k++)
            if (esc_en[k] &&
                {{(hnee_pkg::CP_W-hnee_pkg::CHAR_W){1'b0}}, esc_chars[k]} == cp)
                hit = 1'b1;
        if (cp == '0)
            return;
        if (cp <= 127 && !hit)
        begin
            b.ch   = cp[hnee_pkg::CHAR_W-1:0];
            b.last = 1'b1;
            bytes_due.push_back(b);
        end
        else
            push_text($sformatf("&#%0d;", cp));
    endtask

    task automatic add_char(input logic [hnee_pkg::CP_W-1:0] cp, input string txt);
        stim_row_t r;
        r.kind = ROW_CHAR;
        r.cp   = cp;
        r.idx  = '0;
        r.val  = '0;
        r.txt  = txt;
        rows.push_back(r);
    endtask

    task automatic add_reg(input logic [hnee_pkg::CFG_IDX_W-1:0] idx,
                           input logic [hnee_pkg::CHAR_W-1:0] val);
        stim_row_t r;
        r.kind = ROW_REG;
        r.cp   = '0;
        r.idx  = idx;
        r.val  = val;
        r.txt  = "";
        rows.push_back(r);
    endtask

    task automatic send_char(input logic [hnee_pkg::CP_W-1:0] cp, input string txt);
        if (idle_on && $urandom_range(99) < 35)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        in_valid   <= 1'b1;
        code_point <= cp;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        if (txt == "*")
            escape_code_point(cp);
        else
            push_text(txt);
    endtask

    // zero code points leave nothing behind, so give the pipe time to empty
    task automatic settle();
        in_valid <= 1'b0;
        while (bytes_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [hnee_pkg::CFG_IDX_W-1:0] idx,
                             input logic [hnee_pkg::CHAR_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        @(posedge clk);
        if (idx < hnee_pkg::NUM_ESC)
            esc_chars[idx[1:0]] = val;
        else if (idx == hnee_pkg::REG_ENABLE)
            esc_en = val[hnee_pkg::NUM_ESC-1:0];
    endtask

    task automatic pick_escapes();
        logic [hnee_pkg::CHAR_W-1:0] ch;
        int                          r;
        for (int k = 0; k < hnee_pkg::NUM_ESC; k++)
        begin
            r = $urandom_range(9);
            if (r == 0)
                ch = '0;
            else if (r == 1)
                ch = 7'd127;
            else if (r == 2)
                ch = esc_chars[$urandom_range(hnee_pkg::NUM_ESC - 1)];
            else
                ch = hnee_pkg::CHAR_W'($urandom_range(1, 127));
            write_reg(hnee_pkg::CFG_IDX_W'(hnee_pkg::REG_ESC_A + k), ch);
        end
        // upper data bits are junk for the enable register
        write_reg(hnee_pkg::REG_ENABLE, hnee_pkg::CHAR_W'($urandom_range(127)));
    endtask

    function automatic logic [hnee_pkg::CP_W-1:0] pick_code_point();
        int          r;
        int          nd;
        int unsigned lo;
        int unsigned hi;
        r = $urandom_range(99);
        if (r < 8)
            return '0;
        if (r < 30)
            return hnee_pkg::CP_W'(esc_chars[$urandom_range(hnee_pkg::NUM_ESC - 1)]);
        if (r < 55)
            return hnee_pkg::CP_W'($urandom_range(1, 127));
        if (r < 75)
        begin
            nd = $urandom_range(3, hnee_pkg::MAX_DIGITS);
            lo = 10 ** (nd - 1);
            hi = 10 ** nd - 1;
            if (hi > 2097151)
                hi = 2097151;
            return hnee_pkg::CP_W'($urandom_range(hi, lo));
        end
        if (r < 90)
            return hnee_pkg::CP_W'($urandom());
        if (r < 95)
            return hnee_pkg::CP_W'(128 + $urandom_range(3));
        return hnee_pkg::CP_W'(2097151 - $urandom_range(3));
    endfunction

    // receiver: random stalls, plus one long hold-off on request
    initial
    begin
        out_ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                out_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
            end
            out_ready <= !(idle_on && $urandom_range(99) < 35);
        end
    end

    always @(posedge clk)
    begin
        due_byte_t b;
        if (rst_n && out_valid && out_ready)
        begin
            if (bytes_due.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: unexpected beat, byte %0d last %0b",
                             $realtime, out_byte, run_last);
            end
            else
            begin
                b = bytes_due.pop_front();
                if (out_byte !== b.ch || run_last !== b.last)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("%0t: beat mismatch, byte exp %0d got %0d, last exp %0b got %0b",
                                 $realtime, b.ch, out_byte, b.last, run_last);
                end
            end
        end
    end

    initial
    begin
        #(LIMIT_CYCLES * CLK_PERIOD);
        $display("Some tests failed");
        $finish;
    end

    initial
    begin
        mismatches   = 0;
        idle_on      = 1'b1;
        hold_off_req = 1'b0;
        esc_chars[0] = hnee_pkg::RST_ESC_A;
        esc_chars[1] = hnee_pkg::RST_ESC_B;
        esc_chars[2] = hnee_pkg::RST_ESC_C;
        esc_chars[3] = hnee_pkg::RST_ESC_D;
        esc_en       = hnee_pkg::RST_ENABLE;
        rst_n      <= 1'b0;
        in_valid   <= 1'b0;
        code_point <= '0;
        cfg_wr_en  <= 1'b0;
        cfg_index  <= '0;
        cfg_data   <= '0;

        // defaults after reset
        add_char(0, "");
        add_char(65, "A");
        add_char(1, "*");
        add_char(127, "*");
        add_char(60, "&#60;");
        add_char(62, "&#62;");
        add_char(39, "&#39;");
        add_char(38, "&#38;");
        add_char(128, "&#128;");
        add_char(1000000, "&#1000000;");
        add_char(1114111, "&#1114111;");
        add_char(1114112, "&#1114112;");
        add_char(2097151, "&#2097151;");
        // a zero register, the top character, and one character held twice
        add_reg(hnee_pkg::REG_ESC_A, 7'd0);
        add_reg(hnee_pkg::REG_ESC_B, 7'd127);
        add_reg(hnee_pkg::REG_ESC_C, 7'd65);
        add_reg(hnee_pkg::REG_ESC_D, 7'd65);
        add_reg(hnee_pkg::REG_ENABLE, 7'b0000110);
        add_char(0, "");
        add_char(127, "&#127;");
        add_char(65, "&#65;");
        add_char(60, "<");
        add_reg(hnee_pkg::REG_ENABLE, 7'b0001000);
        add_char(65, "&#65;");
        // everything off, then writes past the last register must not land
        add_reg(hnee_pkg::REG_ENABLE, 7'b0000000);
        for (int i = hnee_pkg::REG_ENABLE + 1; i < (1 << hnee_pkg::CFG_IDX_W); i++)
            add_reg(hnee_pkg::CFG_IDX_W'(i), 7'h7F);
        add_char(65, "A");
        add_char(127, "*");
        add_char(60, "<");

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (rows[i])
        begin
            if (rows[i].kind == ROW_REG)
            begin
                settle();
                write_reg(rows[i].idx, rows[i].val);
            end
            else
                send_char(rows[i].cp, rows[i].txt);
        end

        for (int p = 0; p < PHASES; p++)
        begin
            settle();
            if (p == PHASES - 1)
            begin
                write_reg(hnee_pkg::REG_ESC_A, hnee_pkg::RST_ESC_A);
                write_reg(hnee_pkg::REG_ESC_B, hnee_pkg::RST_ESC_B);
                write_reg(hnee_pkg::REG_ESC_C, hnee_pkg::RST_ESC_C);
                write_reg(hnee_pkg::REG_ESC_D, hnee_pkg::RST_ESC_D);
                write_reg(hnee_pkg::REG_ENABLE, 7'h0F);
            end
            else
                pick_escapes();
            idle_on = (p != 2);
            if (p == 0)
                hold_off_req = 1'b1;   // sender keeps offering while the output is held
            for (int n = 0; n < PHASE_ITEMS; n++)
                send_char(pick_code_point(), "*");
        end
        idle_on = 1'b1;

        settle();
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

>>> html_numeric_entity_escaper_core.f
design/hnee_pkg.sv
design/hnee_front.sv
design/hnee_fifo.sv
design/hnee_back.sv
design/html_numeric_entity_escaper_core.sv
design/hnee_checker.sv
dv/testbench.sv
